### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the life generation block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define TLG_ASSERT_CR(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Short form that uses the block's standard clock and reset names.
`define TLG_ASSERT(name, prop, msg) \
  `TLG_ASSERT_CR(name, clk_i, rst_ni, prop, msg)

`endif

### hdl/tlg_pkg.sv
// ----------------------------------------------------------------------------
// Life generation package
// Types, constants and codes shared by the toroidal life generation block.
// ----------------------------------------------------------------------------
package tlg_pkg;

  // Default grid edge length in cells.
  localparam int GRID_SIZE_DEF = 64;

  // Fixed widths of the transaction fields.
  localparam int IDX_W = 6;
  localparam int ROW_W = 64;

  // Block sums (cell included) that give a live cell.
  localparam logic [3:0] BIRTH_SUM   = 4'd3;
  localparam logic [3:0] SURVIVE_SUM = 4'd4;

  // Command codes.
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // Input transaction.
  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] row_index;
    logic [ROW_W-1:0] row_bits;
  } in_item_t;

  // Output transaction.
  typedef struct packed {
    logic [IDX_W-1:0] out_row_index;
    logic [ROW_W-1:0] out_row_bits;
    logic             last;
    logic             repeats_two_back;
  } out_item_t;

  // Control from the sequencer to the row unit.
  typedef struct packed {
    logic             clear;
    logic             compute;
    logic             is_last;
    logic [IDX_W-1:0] row;
  } row_ctrl_t;

endpackage

### hdl/toroidal_life_generation.sv
// ----------------------------------------------------------------------------
// Toroidal life generation
// Conway B3/S23 generator on a square grid with wrap-around at every edge.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i, in_ready_o, in_item_i) takes commands. A
//   load transaction writes one grid row and gives no result; rows at or
//   beyond GRID_SIZE are ignored. An advance transaction computes the next
//   generation and returns GRID_SIZE output transactions (out_valid_o,
//   out_ready_i, out_item_o), row 0 first, with last set on the final row,
//   which alone can carry the repeat flag. An advance reads each grid row
//   from memory, passes it through the row window and registers each new
//   row for output; rows then follow at one row per cycle while the receiver
//   takes them. in_ready_o is low until the advance is done.
//   When the receiver stalls, the whole row pipeline, including the memory
//   reads, freezes until the held row is taken; no row is lost.
//   Reset clears the row valid flags of the grid and both history banks, so
//   all three read back as dead cells. The history is kept in two banks
//   whose roles swap after each advance.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module toroidal_life_generation
  import tlg_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int AW = $clog2(GRID_SIZE);
  localparam int SW = $clog2(GRID_SIZE + 3);
  localparam logic [SW-1:0] S_RD_END   = SW'(GRID_SIZE - 1);
  localparam logic [SW-1:0] S_TOP      = SW'(GRID_SIZE + 1);
  localparam logic [SW-1:0] S_LAST     = SW'(GRID_SIZE + 2);
  localparam logic [SW-1:0] S_HIST_END = SW'(GRID_SIZE + 1);
  localparam logic [AW-1:0] ROW_LAST   = AW'(GRID_SIZE - 1);

  state_e state_q, state_d;
  logic [SW-1:0] s_q, s_d;
  logic          in_fire;
  logic          load_fire;
  logic          adv_fire;
  logic          run;
  logic          step_en;
  logic          consume;
  logic          compute;
  logic          done;
  logic [AW-1:0] row_cur;

  // Grid memory.
  logic                 grid_we;
  logic [AW-1:0]        grid_waddr;
  logic [GRID_SIZE-1:0] grid_wdata;
  logic                 grid_re;
  logic [AW-1:0]        grid_raddr;
  logic [GRID_SIZE-1:0] grid_rdata;
  logic [GRID_SIZE-1:0] grid_vld_q;
  logic                 grid_rd_vld_q;

  // Row window.
  logic [GRID_SIZE-1:0] d_row;
  logic [GRID_SIZE-1:0] up_q, mid_q, top_q, first_q;

  // History banks.
  logic                 hist_re;
  logic [AW-1:0]        hist_raddr;
  logic [GRID_SIZE-1:0] hist_rdata [2];
  logic [1:0]           hist_vld_q;
  logic                 sel_q;
  logic [GRID_SIZE-1:0] older_row;

  logic [GRID_SIZE-1:0] fresh;
  logic                 row_out_valid;
  row_ctrl_t            row_ctrl;

  // Handshake decode.
  assign in_fire   = in_valid_i && in_ready_o;
  assign load_fire = in_fire && (in_item_i.cmd == CMD_LOAD);
  assign adv_fire  = in_fire && (in_item_i.cmd == CMD_ADVANCE);
  assign run       = (state_q == ST_RUN);
  assign step_en   = run && (!row_out_valid || out_ready_i);
  assign consume   = step_en && (s_q >= SW'(1));
  assign compute   = step_en && (s_q >= SW'(3));
  assign done      = step_en && (s_q == S_LAST);
  assign row_cur   = AW'(s_q - SW'(3));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (adv_fire) state_d = ST_RUN;
      ST_RUN:  if (done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready_o = 1'b0;
    s_d        = s_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        s_d        = '0;
      end
      ST_RUN: begin
        if (step_en) s_d = s_q + SW'(1);
      end
      default: s_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      s_q     <= '0;
    end else begin
      state_q <= state_d;
      s_q     <= s_d;
    end
  end

  // Grid reads go last row first, then rows 0 up to the second to last.
  assign grid_re    = step_en && (s_q <= S_RD_END);
  assign grid_raddr = (s_q == '0) ? ROW_LAST : AW'(s_q - SW'(1));

  // A load writes its row; an advance writes each new row once it is computed.
  always_comb begin
    grid_we    = 1'b0;
    grid_waddr = row_cur;
    grid_wdata = fresh;
    if (load_fire && ({1'b0, in_item_i.row_index} < (IDX_W + 1)'(GRID_SIZE))) begin
      grid_we    = 1'b1;
      grid_waddr = in_item_i.row_index[AW-1:0];
      grid_wdata = in_item_i.row_bits[GRID_SIZE-1:0];
    end else if (compute) begin
      grid_we = 1'b1;
    end
  end

  tlg_ram #(
    .WIDTH (GRID_SIZE),
    .DEPTH (GRID_SIZE)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (grid_we),
    .waddr_i (grid_waddr),
    .wdata_i (grid_wdata),
    .re_i    (grid_re),
    .raddr_i (grid_raddr),
    .rdata_o (grid_rdata)
  );

  // Row valid flags: a row never written since reset reads as dead.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_vld_q    <= '0;
      grid_rd_vld_q <= 1'b0;
    end else begin
      if (grid_we) grid_vld_q[grid_waddr] <= 1'b1;
      if (grid_re) grid_rd_vld_q <= grid_vld_q[grid_raddr];
    end
  end

  // The bottom neighbor comes from memory, then from the saved edge rows.
  always_comb begin
    if (s_q == S_TOP) begin
      d_row = top_q;
    end else if (s_q == S_LAST) begin
      d_row = first_q;
    end else begin
      d_row = grid_rd_vld_q ? grid_rdata : '0;
    end
  end

  // Sliding window of old rows, plus copies of the last and first rows.
  always_ff @(posedge clk_i) begin
    if (consume) begin
      up_q  <= mid_q;
      mid_q <= d_row;
      if (s_q == SW'(1)) top_q   <= d_row;
      if (s_q == SW'(2)) first_q <= d_row;
    end
  end

  // History reads run one step ahead of the row being computed.
  assign hist_re    = step_en && (s_q >= SW'(2)) && (s_q <= S_HIST_END);
  assign hist_raddr = AW'(s_q - SW'(2));

  for (genvar b = 0; b < 2; b++) begin : g_hist
    tlg_ram #(
      .WIDTH (GRID_SIZE),
      .DEPTH (GRID_SIZE)
    ) u_hist_ram (
      .clk_i   (clk_i),
      .we_i    (compute && (sel_q == 1'(b))),
      .waddr_i (row_cur),
      .wdata_i (fresh),
      .re_i    (hist_re),
      .raddr_i (hist_raddr),
      .rdata_o (hist_rdata[b])
    );
  end

  assign older_row = hist_vld_q[sel_q] ? hist_rdata[sel_q] : '0;

  // The older bank is overwritten by the new generation and then becomes the
  // newer one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q      <= 1'b0;
      hist_vld_q <= '0;
    end else if (done) begin
      sel_q             <= !sel_q;
      hist_vld_q[sel_q] <= 1'b1;
    end
  end

  // Row unit control.
  always_comb begin
    row_ctrl.clear   = adv_fire;
    row_ctrl.compute = compute;
    row_ctrl.is_last = (s_q == S_LAST);
    row_ctrl.row     = IDX_W'(row_cur);
  end

  tlg_row_unit #(
    .GRID_SIZE (GRID_SIZE)
  ) u_row_unit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (row_ctrl),
    .up_i        (up_q),
    .mid_i       (mid_q),
    .dn_i        (d_row),
    .older_i     (older_row),
    .out_ready_i (out_ready_i),
    .fresh_o     (fresh),
    .out_valid_o (row_out_valid),
    .out_item_o  (out_item_o)
  );

  assign out_valid_o = row_out_valid;

  // Checks.
  `TLG_ASSERT(a_last_on_final_row,
    (out_valid_o && out_item_o.last) |-> (out_item_o.out_row_index == IDX_W'(GRID_SIZE - 1)),
    "last flag on a row other than the final one")
  `TLG_ASSERT(a_repeat_needs_last,
    (out_valid_o && out_item_o.repeats_two_back) |-> out_item_o.last,
    "repeat flag outside the final row")
  `TLG_ASSERT(a_grid_no_rw_clash,
    (run && grid_we && grid_re) |-> (grid_waddr != grid_raddr),
    "grid row written while it is still being read")
  `TLG_ASSERT(a_bank_swap,
    done |=> (sel_q != $past(sel_q)),
    "history banks did not swap at the end of an advance")

endmodule

### hdl/tlg_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module tlg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/tlg_lane.sv
// ----------------------------------------------------------------------------
// Life cell lane
// Applies the B3/S23 rule to one cell from its 3x3 neighborhood.
// ----------------------------------------------------------------------------
module tlg_lane
  import tlg_pkg::*;
(
  input  logic [8:0] nbhd_i,
  output logic       alive_o
);

  logic [3:0] sum;
  logic       center;

  // The neighborhood is packed row by row, so the cell itself sits in the middle.
  assign center = nbhd_i[4];
  assign sum    = 4'($countones(nbhd_i));

  // A cell lives on a block sum of three, or of four when it is already alive.
  assign alive_o = (sum == BIRTH_SUM) || ((sum == SURVIVE_SUM) && center);

endmodule

### hdl/tlg_row_unit.sv
// ----------------------------------------------------------------------------
// Life row unit
// One lane per column computes a new row; the merge stage assembles the row,
// tracks the repeat check and holds the output register.
// ----------------------------------------------------------------------------
module tlg_row_unit
  import tlg_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  row_ctrl_t            ctrl_i,
  input  logic [GRID_SIZE-1:0] up_i,
  input  logic [GRID_SIZE-1:0] mid_i,
  input  logic [GRID_SIZE-1:0] dn_i,
  input  logic [GRID_SIZE-1:0] older_i,
  input  logic                 out_ready_i,
  output logic [GRID_SIZE-1:0] fresh_o,
  output logic                 out_valid_o,
  output out_item_t            out_item_o
);

  logic [GRID_SIZE-1:0] fresh;
  logic                 row_same;
  logic                 same_q;
  logic                 out_valid_q;
  out_item_t            out_item_q;

  // One lane per column, with wrap-around at the left and right edges.
  for (genvar c = 0; c < GRID_SIZE; c++) begin : g_lane
    localparam int Lf = (c + GRID_SIZE - 1) % GRID_SIZE;
    localparam int Rt = (c + 1) % GRID_SIZE;
    tlg_lane u_lane (
      .nbhd_i  ({up_i[Lf],  up_i[c],  up_i[Rt],
                 mid_i[Lf], mid_i[c], mid_i[Rt],
                 dn_i[Lf],  dn_i[c],  dn_i[Rt]}),
      .alive_o (fresh[c])
    );
  end

  assign fresh_o  = fresh;
  assign row_same = (fresh == older_i);

  // Running match against the generation from two advances back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      same_q <= 1'b1;
    end else if (ctrl_i.clear) begin
      same_q <= 1'b1;
    end else if (ctrl_i.compute) begin
      same_q <= same_q && row_same;
    end
  end

  // Output valid: set by a new row, cleared once the row is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.compute) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.compute) begin
      out_item_q.out_row_index    <= ctrl_i.row;
      out_item_q.out_row_bits     <= ROW_W'(fresh);
      out_item_q.last             <= ctrl_i.is_last;
      out_item_q.repeats_two_back <= ctrl_i.is_last && same_q && row_same;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### bench/life_row_checker.sv
// ----------------------------------------------------------------------------
// Life generation row checker
// Watches both channels of the toroidal life generation block. It keeps its
// own copy of the grid and of the two history generations, works out every
// row that an advance transaction must return, and compares each returned
// row field by field with the oldest expected row.
// ----------------------------------------------------------------------------
module life_row_checker
  import tlg_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_rows_o
);

  // Columns at or beyond the grid edge never hold a live cell.
  localparam logic [ROW_W-1:0] COL_MASK =
    (GRID_SIZE >= ROW_W) ? '1 : ((64'd1 << GRID_SIZE) - 64'd1);

  logic [ROW_W-1:0] cur_grid  [GRID_SIZE];
  logic [ROW_W-1:0] prev_gen  [GRID_SIZE];
  logic [ROW_W-1:0] prev2_gen [GRID_SIZE];
  out_item_t        expected_rows [$];
  int               mismatches;

  // Next state of one row, with wrap-around on rows and columns.
  function automatic logic [ROW_W-1:0] evolve_row(int r);
    logic [ROW_W-1:0] res;
    int               sum;
    res = '0;
    for (int c = 0; c < GRID_SIZE; c++) begin
      sum = 0;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          sum += cur_grid[(r + dr + GRID_SIZE) % GRID_SIZE][(c + dc + GRID_SIZE) % GRID_SIZE];
        end
      end
      if (sum == BIRTH_SUM || (sum == SURVIVE_SUM && cur_grid[r][c])) begin
        res[c] = 1'b1;
      end
    end
    return res;
  endfunction

  // Build the whole next generation, queue its rows and shift the history.
  task automatic advance_generation();
    logic [ROW_W-1:0] fresh [GRID_SIZE];
    logic             same;
    out_item_t        row_item;
    same = 1'b1;
    for (int r = 0; r < GRID_SIZE; r++) begin
      fresh[r] = evolve_row(r) & COL_MASK;
      if (fresh[r] != prev2_gen[r]) same = 1'b0;
    end
    for (int r = 0; r < GRID_SIZE; r++) begin
      row_item.out_row_index    = IDX_W'(r);
      row_item.out_row_bits     = fresh[r];
      row_item.last             = (r == GRID_SIZE - 1);
      row_item.repeats_two_back = (r == GRID_SIZE - 1) && same;
      expected_rows.push_back(row_item);
    end
    for (int r = 0; r < GRID_SIZE; r++) begin
      prev2_gen[r] = prev_gen[r];
      prev_gen[r]  = fresh[r];
      cur_grid[r]  = fresh[r];
    end
  endtask

  // Report one field that differs from its expected value.
  task automatic report_field(string field, logic [ROW_W-1:0] want, logic [ROW_W-1:0] got);
    mismatches++;
    $display("%0t: mismatch in %s: expected %h, actual %h", $time, field, want, got);
  endtask

  // Compare one returned row with the oldest expected row.
  task automatic check_row(out_item_t got);
    out_item_t want;
    if (expected_rows.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected row transaction: expected none, actual %h", $time, got);
    end else begin
      want = expected_rows.pop_front();
      if (got.out_row_index != want.out_row_index) begin
        report_field("out_row_index", ROW_W'(want.out_row_index),
                     ROW_W'(got.out_row_index));
      end
      if (got.out_row_bits != want.out_row_bits) begin
        report_field("out_row_bits", want.out_row_bits, got.out_row_bits);
      end
      if (got.last != want.last) begin
        report_field("last", ROW_W'(want.last), ROW_W'(got.last));
      end
      if (got.repeats_two_back != want.repeats_two_back) begin
        report_field("repeats_two_back", ROW_W'(want.repeats_two_back),
                     ROW_W'(got.repeats_two_back));
      end
    end
  endtask

  // Follow the accepted transactions on both channels.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < GRID_SIZE; r++) begin
        cur_grid[r]  = '0;
        prev_gen[r]  = '0;
        prev2_gen[r] = '0;
      end
      expected_rows.delete();
      mismatches = 0;
      fail_count_o   <= 0;
      pending_rows_o <= 0;
    end else begin
      // Rows of an earlier advance are checked before a new command is taken.
      if (out_valid_i && out_ready_i) check_row(out_item_i);
      if (in_valid_i && in_ready_i) begin
        if (in_item_i.cmd == CMD_LOAD) begin
          if (in_item_i.row_index < GRID_SIZE) begin
            cur_grid[in_item_i.row_index] = in_item_i.row_bits & COL_MASK;
          end
        end else begin
          advance_generation();
        end
      end
      fail_count_o   <= mismatches;
      pending_rows_o <= expected_rows.size();
    end
  end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Toroidal life generation testbench
// Loads rows and advances generations on the life block: first a short
// directed run over empty grids, wrapping patterns and extreme rows, then
// random reseeding with patterns and random rows followed by advances. Both
// channels idle at random; the receiver also holds off for long stretches.
// The checker beside the block predicts and compares every returned row.
// ----------------------------------------------------------------------------
module testbench
  import tlg_pkg::*;
();

  localparam int TARGET_ITEMS = 470;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_PCT     = 19;

  typedef enum int {
    PAT_BLINKER,
    PAT_BLOCK,
    PAT_GLIDER
  } pattern_e;

  logic      clk        = 1'b0;
  logic      rst_n      = 1'b0;
  logic      in_valid   = 1'b0;
  logic      in_ready;
  in_item_t  in_item    = '0;
  logic      out_valid;
  logic      out_ready  = 1'b0;
  out_item_t out_item;
  logic      calm       = 1'b0;
  int        hold_asked = 0;
  int        hold_served;
  int        hold_left;
  int        fail_count;
  int        pending_rows;
  int        items_sent = 0;

  // Clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  toroidal_life_generation dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  life_row_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_item_i      (in_item),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_item_i     (out_item),
    .fail_count_o   (fail_count),
    .pending_rows_o (pending_rows)
  );

  // Receiver: random stalls, calm stretches and requested long hold-offs.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left   = 0;
      hold_served = 0;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Offer one transaction, after an optional random gap, until it is taken.
  task automatic send(logic cmd, logic [IDX_W-1:0] idx, logic [ROW_W-1:0] bits);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_item.cmd       <= cmd;
    in_item.row_index <= idx;
    in_item.row_bits  <= bits;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Advance with random content in the ignored fields.
  task automatic advance();
    send(CMD_ADVANCE, IDX_W'($urandom_range(63)), {$urandom, $urandom});
  endtask

  function automatic logic [ROW_W-1:0] rotl(logic [ROW_W-1:0] bits, int n);
    return (bits << n) | (bits >> (ROW_W - n));
  endfunction

  // Random row at one of three densities.
  function automatic logic [ROW_W-1:0] random_row();
    case ($urandom_range(2))
      0:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      1:       return {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Write a small pattern into three rows starting at row r, column c.
  task automatic stamp(pattern_e kind, int r, int c);
    logic [2:0] rows [3];
    case (kind)
      PAT_BLINKER: rows = '{3'b000, 3'b111, 3'b000};
      PAT_BLOCK:   rows = '{3'b011, 3'b011, 3'b000};
      default:     rows = '{3'b010, 3'b100, 3'b111};
    endcase
    for (int k = 0; k < 3; k++) begin
      send(CMD_LOAD, IDX_W'((r + k) % 64), rotl(ROW_W'(rows[k]), c));
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int seq_no;
    int style;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty grid right after reset: both histories are empty, so it repeats.
    advance();
    advance();
    // Horizontal blinker across the column wrap, then three advances.
    send(CMD_LOAD, 6'd0, rotl(64'h7, 63));
    advance();
    advance();
    advance();
    // Extreme rows and the row wrap.
    send(CMD_LOAD, 6'd63, '1);
    send(CMD_LOAD, 6'd0, '0);
    send(CMD_LOAD, 6'd1, 64'h8000_0000_0000_0001);
    send(CMD_LOAD, 6'd32, 64'h5555_5555_5555_5555);
    send(CMD_LOAD, 6'd33, 64'hAAAA_AAAA_AAAA_AAAA);
    advance();
    advance();
    // Glider over the corner where rows and columns both wrap.
    stamp(PAT_GLIDER, 62, 62);
    advance();

    // Random sequences of loads followed by advances.
    seq_no = 0;
    while (items_sent < TARGET_ITEMS) begin
      calm <= (seq_no >= 12 && seq_no < 28);
      if (seq_no == 5 || seq_no == 40) hold_asked <= hold_asked + 1;
      style = $urandom_range(99);
      if (style < 12) begin
        // Noise: loose transactions of either kind.
        repeat ($urandom_range(1, 3)) begin
          send(logic'($urandom_range(1)), IDX_W'($urandom_range(63)), {$urandom, $urandom});
        end
      end else if (style < 30) begin
        // Let the grid settle towards still lifes and oscillators.
        repeat ($urandom_range(2, 5)) advance();
      end else begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(1)) begin
            stamp(pattern_e'($urandom_range(2)), $urandom_range(63), $urandom_range(63));
          end else begin
            send(CMD_LOAD, IDX_W'($urandom_range(63)), random_row());
          end
        end
        repeat ($urandom_range(1, 3)) advance();
      end
      seq_no++;
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    // Drain the expected rows, then allow for the block's latency.
    do @(posedge clk); while (pending_rows != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Timeout far beyond the slowest correct run.
  initial begin
    #800000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/tlg_pkg.sv
hdl/tlg_ram.sv
hdl/tlg_lane.sv
hdl/tlg_row_unit.sv
hdl/toroidal_life_generation.sv
bench/life_row_checker.sv
bench/testbench.sv
